/* hdl/mbpfr_pkg.sv */
// Shared constants for the meter bus poll and frame receive block.
// Used by the channel interfaces and the top level; no dependencies.
package mbpfr_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int POS_W        = 10;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_RX    = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_RXB  = 2'd1;
  localparam logic [1:0] KIND_OK   = 2'd2;
  localparam logic [1:0] KIND_FAIL = 2'd3;

  localparam logic [1:0] MODE_POLL  = 2'd0;
  localparam logic [1:0] MODE_FAIL  = 2'd1;
  localparam logic [1:0] MODE_RX    = 2'd2;
  localparam logic [1:0] MODE_RX_OK = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TIME   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 8'd1;

  localparam logic [7:0] LONG_START  = 8'h68;
  localparam logic [7:0] FRAME_STOP  = 8'h16;
  localparam logic [7:0] SHORT_START = 8'h10;
  localparam logic [7:0] REQ_UD2     = 8'h5B;

  localparam logic [8:0] LEN_UNKNOWN  = 9'h1FF;
  localparam logic [8:0] LEN_OVERHEAD = 9'd6;
  localparam logic [POS_W-1:0] HEADER_LEN  = 10'd7;
  localparam logic [POS_W-1:0] POS_LEN2    = 10'd3;
  localparam logic [POS_W-1:0] POS_LEN1    = 10'd2;
  localparam logic [POS_W-1:0] POS_START   = 10'd1;
  localparam logic [POS_W-1:0] BUFFER_FULL = POS_W'(BUFFER_DEPTH);

  localparam logic [2:0] POLL_LAST = 3'd4;

  localparam logic [15:0] WAIT_RESET  = 16'd3;
  localparam logic [7:0]  RETRY_RESET = 8'd3;

endpackage

/* hdl/mbpfr_ifs.sv */
// Valid/ready channel interfaces for item, result and configuration transfers.
// Depends on mbpfr_pkg for widths.
interface mbpfr_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] meter_address;
  logic [7:0] rx_byte;
  modport source (output valid, op, meter_address, rx_byte, input ready);
  modport sink (input valid, op, meter_address, rx_byte, output ready);
endinterface

interface mbpfr_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [8:0] position;
  logic       last;
  modport source (output valid, kind, value, position, last, input ready);
  modport sink (input valid, kind, value, position, last, output ready);
endinterface

interface mbpfr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mbpfr_pkg::CFG_IDX_W-1:0]    index;
  logic [mbpfr_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/meter_bus_poll_and_frame_receive.sv */
// Meter bus master: polls a meter with a short frame and receives the long reply frame.
// Depends on mbpfr_pkg and the channel interfaces in mbpfr_ifs.sv.
//
// Each item is decoded in the cycle it is accepted and its results are loaded into a
// result holding register, which emits one result per cycle while results are taken.
// An item that yields one result (or none) is taken every cycle unless results stall;
// a poll or retry yields five transmit bytes and a closing reply byte yields two, so
// the next item waits for the last of them. Configuration writes are taken every cycle.
module meter_bus_poll_and_frame_receive (
  input  logic                   clk,
  input  logic                   rst,
  mbpfr_item_if.sink             items,
  mbpfr_result_if.source         results,
  mbpfr_cfg_if.sink              cfg
);

  logic [15:0]                   wait_time;
  logic [7:0]                    retry_limit;
  logic [mbpfr_pkg::POS_W-1:0]   rx_position;
  logic [8:0]                    needed_length;
  logic [7:0]                    length_byte;
  logic                          waiting_for_reply;
  logic [15:0]                   elapsed_ticks;
  logic [7:0]                    attempts_left;
  logic [7:0]                    polled_address;

  logic [mbpfr_pkg::POS_W-1:0]   rx_position_next;
  logic [8:0]                    needed_length_next;
  logic [7:0]                    length_byte_next;
  logic                          waiting_for_reply_next;
  logic [15:0]                   elapsed_ticks_next;
  logic [7:0]                    attempts_left_next;
  logic [7:0]                    polled_address_next;

  logic                          hold_valid;
  logic [1:0]                    hold_mode;
  logic [2:0]                    hold_idx;
  logic [7:0]                    hold_byte;
  logic [8:0]                    hold_pos;

  logic                          load;
  logic [1:0]                    load_mode;
  logic [7:0]                    load_byte;
  logic [8:0]                    load_pos;

  logic                          in_fire;
  logic                          out_fire;
  logic                          out_last;
  logic [mbpfr_pkg::POS_W-1:0]   count;
  logic [16:0]                   elapsed_inc;
  logic [7:0]                    attempts_dec;

  assign in_fire  = items.valid && items.ready;
  assign out_fire = results.valid && results.ready;
  assign items.ready   = !hold_valid || (results.ready && out_last);
  assign results.valid = hold_valid;
  assign cfg.ready     = 1'b1;
  assign results.last  = out_last;

  assign count        = rx_position + 1'b1;
  assign elapsed_inc  = {1'b0, elapsed_ticks} + 17'd1;
  assign attempts_dec = (attempts_left != 8'd0) ? attempts_left - 8'd1 : 8'd0;

  always_comb begin
    rx_position_next       = rx_position;
    needed_length_next     = needed_length;
    length_byte_next       = length_byte;
    waiting_for_reply_next = waiting_for_reply;
    elapsed_ticks_next     = elapsed_ticks;
    attempts_left_next     = attempts_left;
    polled_address_next    = polled_address;
    load      = 1'b0;
    load_mode = mbpfr_pkg::MODE_FAIL;
    load_byte = items.rx_byte;
    load_pos  = rx_position[8:0];
    unique case (items.op)
      mbpfr_pkg::OP_START: begin
        polled_address_next = items.meter_address;
        load      = 1'b1;
        load_byte = items.meter_address;
        rx_position_next   = '0;
        needed_length_next = mbpfr_pkg::LEN_UNKNOWN;
        if (retry_limit == 8'd0) begin
          waiting_for_reply_next = 1'b0;
          attempts_left_next     = 8'd0;
          load_mode              = mbpfr_pkg::MODE_FAIL;
        end else begin
          attempts_left_next     = retry_limit;
          elapsed_ticks_next     = '0;
          waiting_for_reply_next = 1'b1;
          load_mode              = mbpfr_pkg::MODE_POLL;
        end
      end
      mbpfr_pkg::OP_RX: begin
        if (waiting_for_reply) begin
          load             = 1'b1;
          load_mode        = mbpfr_pkg::MODE_RX;
          rx_position_next = count;
          if (count > mbpfr_pkg::HEADER_LEN) begin
            if (items.rx_byte == mbpfr_pkg::FRAME_STOP &&
                count == {1'b0, needed_length}) begin
              waiting_for_reply_next = 1'b0;
              attempts_left_next     = 8'd0;
              load_mode              = mbpfr_pkg::MODE_RX_OK;
            end else if (count > {1'b0, needed_length} ||
                         count >= mbpfr_pkg::BUFFER_FULL) begin
              rx_position_next   = '0;
              needed_length_next = mbpfr_pkg::LEN_UNKNOWN;
            end
          end else if (count == mbpfr_pkg::POS_LEN2) begin
            if (items.rx_byte == length_byte) begin
              needed_length_next = {1'b0, items.rx_byte} + mbpfr_pkg::LEN_OVERHEAD;
            end else begin
              rx_position_next = '0;
            end
          end else if (count == mbpfr_pkg::POS_LEN1) begin
            length_byte_next = items.rx_byte;
          end else if (count == mbpfr_pkg::POS_START) begin
            if (items.rx_byte != mbpfr_pkg::LONG_START) begin
              rx_position_next = '0;
            end
          end
        end
      end
      mbpfr_pkg::OP_TICK: begin
        if (waiting_for_reply) begin
          if (elapsed_inc > {1'b0, wait_time}) begin
            attempts_left_next = attempts_dec;
            load               = 1'b1;
            load_byte          = polled_address;
            rx_position_next   = '0;
            needed_length_next = mbpfr_pkg::LEN_UNKNOWN;
            if (attempts_dec == 8'd0) begin
              waiting_for_reply_next = 1'b0;
              load_mode              = mbpfr_pkg::MODE_FAIL;
            end else begin
              elapsed_ticks_next = '0;
              load_mode          = mbpfr_pkg::MODE_POLL;
            end
          end else begin
            elapsed_ticks_next = elapsed_inc[15:0];
          end
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_comb begin
    results.kind     = mbpfr_pkg::KIND_FAIL;
    results.value    = 8'd0;
    results.position = 9'd0;
    out_last         = 1'b1;
    unique case (hold_mode)
      mbpfr_pkg::MODE_POLL: begin
        results.kind = mbpfr_pkg::KIND_TX;
        out_last     = (hold_idx == mbpfr_pkg::POLL_LAST);
        case (hold_idx)
          3'd0:    results.value = mbpfr_pkg::SHORT_START;
          3'd1:    results.value = mbpfr_pkg::REQ_UD2;
          3'd2:    results.value = hold_byte;
          3'd3:    results.value = hold_byte + mbpfr_pkg::REQ_UD2;
          default: results.value = mbpfr_pkg::FRAME_STOP;
        endcase
      end
      mbpfr_pkg::MODE_FAIL: begin
        results.kind = mbpfr_pkg::KIND_FAIL;
      end
      mbpfr_pkg::MODE_RX: begin
        results.kind     = mbpfr_pkg::KIND_RXB;
        results.value    = hold_byte;
        results.position = hold_pos;
      end
      mbpfr_pkg::MODE_RX_OK: begin
        if (hold_idx == 3'd0) begin
          results.kind     = mbpfr_pkg::KIND_RXB;
          results.value    = hold_byte;
          results.position = hold_pos;
          out_last         = 1'b0;
        end else begin
          results.kind = mbpfr_pkg::KIND_OK;
        end
      end
      default: begin
        results.kind = mbpfr_pkg::KIND_FAIL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_time         <= mbpfr_pkg::WAIT_RESET;
      retry_limit       <= mbpfr_pkg::RETRY_RESET;
      rx_position       <= '0;
      needed_length     <= mbpfr_pkg::LEN_UNKNOWN;
      length_byte       <= 8'd0;
      waiting_for_reply <= 1'b0;
      elapsed_ticks     <= 16'd0;
      attempts_left     <= 8'd0;
      polled_address    <= 8'd0;
      hold_valid        <= 1'b0;
      hold_mode         <= mbpfr_pkg::MODE_FAIL;
      hold_idx          <= 3'd0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == mbpfr_pkg::CFG_WAIT_TIME) begin
          wait_time <= cfg.data;
        end else if (cfg.index == mbpfr_pkg::CFG_RETRY_LIMIT) begin
          retry_limit <= cfg.data[7:0];
        end
      end
      if (out_fire) begin
        if (out_last) begin
          hold_valid <= 1'b0;
        end else begin
          hold_idx <= hold_idx + 3'd1;
        end
      end
      if (in_fire) begin
        rx_position       <= rx_position_next;
        needed_length     <= needed_length_next;
        length_byte       <= length_byte_next;
        waiting_for_reply <= waiting_for_reply_next;
        elapsed_ticks     <= elapsed_ticks_next;
        attempts_left     <= attempts_left_next;
        polled_address    <= polled_address_next;
        if (load) begin
          hold_valid <= 1'b1;
          hold_mode  <= load_mode;
          hold_idx   <= 3'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && load) begin
      hold_byte <= load_byte;
      hold_pos  <= load_pos;
    end
  end

  a_idx_holds: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !results.ready |=> $stable(hold_idx))
    else $error("result index moved while stalled");

  a_ok_is_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.kind == mbpfr_pkg::KIND_OK |-> results.last)
    else $error("success result not marked last");

  a_ready_only_at_end: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> (!hold_valid || out_last))
    else $error("item taken before burst ends");

  a_poll_idx_range: assert property (@(posedge clk) disable iff (rst)
    hold_valid && hold_mode == mbpfr_pkg::MODE_POLL |-> hold_idx <= mbpfr_pkg::POLL_LAST)
    else $error("poll burst index out of range");

  a_fail_disarms: assert property (@(posedge clk) disable iff (rst)
    in_fire && load && load_mode == mbpfr_pkg::MODE_FAIL |=> !waiting_for_reply)
    else $error("receiver still armed after failure");

endmodule

/* tb/sv/tb.sv */
// Testbench for meter_bus_poll_and_frame_receive: short-frame polls, long-frame replies,
// tick timeouts and retries, checked against a cycle-free predictor held in a scoreboard.
// Depends on mbpfr_pkg, the channel interfaces in mbpfr_ifs.sv and the top level RTL.
module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [8:0] position;
    logic       last;
  } poll_result_t;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  class poll_tracker;
    logic [15:0] wait_ticks;
    logic [7:0]  retry_max;
    logic [9:0]  rx_pos;
    logic [8:0]  need_len;
    logic [7:0]  len_byte;
    bit          armed;
    logic [15:0] elapsed;
    logic [7:0]  attempts;
    logic [7:0]  poll_addr;
    poll_result_t owed_results[$];
    int          errors;
    int          taken;

    function new();
      wait_ticks = mbpfr_pkg::WAIT_RESET;
      retry_max  = mbpfr_pkg::RETRY_RESET;
      rx_pos     = '0;
      need_len   = mbpfr_pkg::LEN_UNKNOWN;
      len_byte   = '0;
      armed      = 1'b0;
      elapsed    = '0;
      attempts   = '0;
      poll_addr  = '0;
      errors     = 0;
      taken      = 0;
    endfunction

    function void set_reg(logic [mbpfr_pkg::CFG_IDX_W-1:0] idx,
                          logic [mbpfr_pkg::CFG_DATA_W-1:0] val);
      if (idx == mbpfr_pkg::CFG_WAIT_TIME) begin
        wait_ticks = val;
      end else if (idx == mbpfr_pkg::CFG_RETRY_LIMIT) begin
        retry_max = val[7:0];
      end
    endfunction

    function void owe(logic [1:0] kind, logic [7:0] value, logic [8:0] pos);
      owed_results.push_back('{kind, value, pos, 1'b0});
    endfunction

    function void restart_rx();
      rx_pos   = '0;
      need_len = mbpfr_pkg::LEN_UNKNOWN;
    endfunction

    function void send_poll();
      owe(mbpfr_pkg::KIND_TX, mbpfr_pkg::SHORT_START, '0);
      owe(mbpfr_pkg::KIND_TX, mbpfr_pkg::REQ_UD2, '0);
      owe(mbpfr_pkg::KIND_TX, poll_addr, '0);
      owe(mbpfr_pkg::KIND_TX, mbpfr_pkg::REQ_UD2 + poll_addr, '0);
      owe(mbpfr_pkg::KIND_TX, mbpfr_pkg::FRAME_STOP, '0);
      restart_rx();
      elapsed = '0;
      armed   = 1'b1;
    endfunction

    function void take_item(logic [1:0] op, logic [7:0] addr, logic [7:0] rx);
      logic [9:0]   count;
      logic [16:0]  next_elapsed;
      int           n0;
      poll_result_t r;
      n0 = owed_results.size();
      case (op)
        mbpfr_pkg::OP_START: begin
          taken++;
          poll_addr = addr;
          if (retry_max == 0) begin
            armed    = 1'b0;
            attempts = '0;
            restart_rx();
            owe(mbpfr_pkg::KIND_FAIL, '0, '0);
          end else begin
            attempts = retry_max;
            send_poll();
          end
        end
        mbpfr_pkg::OP_RX: begin
          if (armed) begin
            taken++;
            owe(mbpfr_pkg::KIND_RXB, rx, rx_pos[8:0]);
            rx_pos = rx_pos + 10'd1;
            count  = rx_pos;
            if (count > mbpfr_pkg::HEADER_LEN) begin
              if (rx == mbpfr_pkg::FRAME_STOP && count == {1'b0, need_len}) begin
                armed    = 1'b0;
                attempts = '0;
                owe(mbpfr_pkg::KIND_OK, '0, '0);
              end else if (count > {1'b0, need_len} || count >= mbpfr_pkg::BUFFER_FULL) begin
                restart_rx();
              end
            end else if (count == mbpfr_pkg::POS_LEN2) begin
              if (rx == len_byte) begin
                need_len = {1'b0, rx} + mbpfr_pkg::LEN_OVERHEAD;
              end else begin
                rx_pos = '0;
              end
            end else if (count == mbpfr_pkg::POS_LEN1) begin
              len_byte = rx;
            end else if (count == mbpfr_pkg::POS_START && rx != mbpfr_pkg::LONG_START) begin
              rx_pos = '0;
            end
          end
        end
        mbpfr_pkg::OP_TICK: begin
          if (armed) begin
            taken++;
            next_elapsed = {1'b0, elapsed} + 17'd1;
            if (next_elapsed > {1'b0, wait_ticks}) begin
              if (attempts > 0) attempts--;
              if (attempts == 0) begin
                armed = 1'b0;
                restart_rx();
                owe(mbpfr_pkg::KIND_FAIL, '0, '0);
              end else begin
                send_poll();
              end
            end else begin
              elapsed = next_elapsed[15:0];
            end
          end
        end
        default: ;
      endcase
      if (owed_results.size() > n0) begin
        r = owed_results.pop_back();
        r.last = 1'b1;
        owed_results.push_back(r);
      end
    endfunction

    function void check_result(poll_result_t got);
      poll_result_t want;
      if (owed_results.size() == 0) begin
        $error("result with none expected: kind %0d value %0h position %0d last %0d",
               got.kind, got.value, got.position, got.last);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("value: expected %0h, got %0h", want.value, got.value);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   sink_stall_pct;

  poll_tracker sb = new();

  mbpfr_item_if   items_ch();
  mbpfr_result_if results_ch();
  mbpfr_cfg_if    cfg_ch();

  meter_bus_poll_and_frame_receive u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_ch.valid && results_ch.ready) begin
        sb.check_result('{results_ch.kind, results_ch.value, results_ch.position,
                          results_ch.last});
      end
      results_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_item(logic [1:0] op, logic [7:0] addr, logic [7:0] rx);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      items_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    items_ch.valid         <= 1'b1;
    items_ch.op            <= op;
    items_ch.meter_address <= addr;
    items_ch.rx_byte       <= rx;
    do @(posedge clk); while (!items_ch.ready);
    sb.take_item(op, addr, rx);
  endtask

  task automatic drain();
    items_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [mbpfr_pkg::CFG_IDX_W-1:0] idx,
                           logic [mbpfr_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_reply(int len_l, bit corrupt, bit with_ticks);
    int         total;
    int         bad_at;
    logic [7:0] b;
    total  = len_l + 6;
    bad_at = corrupt ? $urandom_range(total, 1) : 0;
    for (int i = 1; i <= total; i++) begin
      if (i == 1) begin
        b = mbpfr_pkg::LONG_START;
      end else if (i == 2 || i == 3) begin
        b = len_l[7:0];
      end else if (i == total) begin
        b = mbpfr_pkg::FRAME_STOP;
      end else begin
        b = rand_byte();
      end
      if (i == bad_at) b = rand_byte();
      if (with_ticks && $urandom_range(9) == 0) begin
        send_item(mbpfr_pkg::OP_TICK, rand_byte(), rand_byte());
      end
      send_item(mbpfr_pkg::OP_RX, rand_byte(), b);
    end
  endtask

  task automatic run_random(int target);
    int r;
    int n;
    int len_l;
    while (sb.taken < target) begin
      r = $urandom_range(99);
      if (r < 55) begin
        send_item(mbpfr_pkg::OP_START, rand_byte(), rand_byte());
        len_l = $urandom_range(12, 2);
        send_reply(len_l, $urandom_range(9) == 0, $urandom_range(3) == 0);
      end else if (r < 70) begin
        send_item(mbpfr_pkg::OP_START, rand_byte(), rand_byte());
        n = $urandom_range(12, 1);
        repeat (n) send_item(mbpfr_pkg::OP_TICK, rand_byte(), rand_byte());
      end else if (r < 80) begin
        send_item(mbpfr_pkg::OP_START, rand_byte(), rand_byte());
        n = $urandom_range(10, 1);
        repeat (n) send_item(mbpfr_pkg::OP_RX, rand_byte(), rand_byte());
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) send_item(2'($urandom_range(3)), rand_byte(), rand_byte());
      end
    end
  endtask

  initial begin
    logic [7:0]  overrun_frame [$];
    logic [7:0]  good_frame [$];
    logic [15:0] wait_set [6];
    logic [7:0]  retry_set [6];
    overrun_frame = '{8'h68, 8'h02, 8'h02, 8'h68, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00};
    good_frame    = '{8'h68, 8'h02, 8'h02, 8'h68, 8'h00, 8'hFF, 8'h00, 8'h16};
    wait_set      = '{16'd3, 16'd0, 16'd65535, 16'd2, 16'd1, 16'd5};
    retry_set     = '{8'd3, 8'd1, 8'd255, 8'd0, 8'd4, 8'd2};
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rst                    <= 1'b1;
    items_ch.valid         <= 1'b0;
    items_ch.op            <= mbpfr_pkg::OP_START;
    items_ch.meter_address <= '0;
    items_ch.rx_byte       <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= mbpfr_pkg::CFG_WAIT_TIME;
    cfg_ch.data            <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(mbpfr_pkg::OP_RX, 8'hFF, 8'hFF);
    send_item(mbpfr_pkg::OP_TICK, 8'hFF, 8'hFF);
    send_item(OP_UNUSED, 8'hFF, 8'hFF);
    send_item(mbpfr_pkg::OP_START, 8'hFF, 8'h00);
    send_item(mbpfr_pkg::OP_RX, 8'h00, 8'h00);
    send_item(mbpfr_pkg::OP_RX, 8'h00, mbpfr_pkg::LONG_START);
    send_item(mbpfr_pkg::OP_RX, 8'h00, 8'h05);
    send_item(mbpfr_pkg::OP_RX, 8'h00, 8'h06);
    send_item(mbpfr_pkg::OP_START, 8'h00, 8'h00);
    repeat (4) send_item(mbpfr_pkg::OP_TICK, 8'h00, 8'h00);
    foreach (overrun_frame[i]) send_item(mbpfr_pkg::OP_RX, 8'h00, overrun_frame[i]);
    foreach (good_frame[i]) send_item(mbpfr_pkg::OP_RX, 8'h00, good_frame[i]);
    drain();
    write_reg(mbpfr_pkg::CFG_RETRY_LIMIT, 16'd0);
    send_item(mbpfr_pkg::OP_START, 8'hA5, 8'h00);
    drain();

    for (int k = 0; k < 6; k++) begin
      write_reg(mbpfr_pkg::CFG_WAIT_TIME, wait_set[k]);
      write_reg(mbpfr_pkg::CFG_RETRY_LIMIT, {8'd0, retry_set[k]});
      src_idle_pct   = (k % 4 == 1) ? 49 : (k % 4 == 3) ? 36 : 0;
      sink_stall_pct = (k % 4 == 2) ? 49 : (k % 4 == 3) ? 36 : 0;
      if (k == 2) begin
        send_item(mbpfr_pkg::OP_START, rand_byte(), rand_byte());
        send_reply(251, 1'b0, 1'b0);
      end
      run_random(sb.taken + 5);
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
